// ----- design/bmms_pkg.sv -----
// bmms_pkg: shared types and constants of the binned min/max/mean statistics block
// holds the bin record layout, field widths and the control state type
// no dependencies
`timescale 1ns / 1ps

package bmms_pkg;

  localparam int VAL_W     = 64;
  localparam int CNT_W     = 32;
  localparam int EDGE_W    = 16;
  localparam int DIV_STEPS = VAL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // one bin as stored in the table memory
  typedef struct packed {
    logic              used;
    logic              mism;
    logic [EDGE_W-1:0] edge_mode;
    logic [CNT_W-1:0]  cnt;
    logic [VAL_W-1:0]  sum;
    logic [VAL_W-1:0]  minv;
    logic [VAL_W-1:0]  maxv;
  } bin_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DIV
  } state_t;

endpackage

// ----- design/bmms_ram.sv -----
// bmms_ram: generic single-write, single-read synchronous ram
// read data is registered
// no dependencies
`timescale 1ns / 1ps

module bmms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/bmms_div.sv -----
// bmms_div: restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle
// done pulses for one cycle once the quotient is ready
// depends on bmms_pkg
`timescale 1ns / 1ps

module bmms_div
  import bmms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [VAL_W-1:0] quotient
);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [VAL_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;

  assign shifted = {rem_r, quo_r[VAL_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (run_r) begin
      // remainder stays below the divisor, so the shifted value fits in CNT_W+1 bits
      if (!diff[CNT_W]) begin
        rem_nxt = diff[CNT_W-1:0];
        quo_nxt = {quo_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[CNT_W-1:0];
        quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/binned_min_max_mean_stats.sv -----
// binned_min_max_mean_stats: per-bin min / max / mean statistics table
// uses bmms_pkg, bmms_ram (bin table) and bmms_div (mean divider)
//
//   channel   handshake            payload
//   request   start / busy         in_mode, in_event_id, in_set_index, in_edge_code,
//                                  in_sample_value
//   result    out_valid (strobe)   out_bin_valid, out_sample_count, out_bin_edge,
//                                  out_mean_value, out_min_value, out_max_value,
//                                  out_edge_mismatch
//
// an in-range record request reads the table, then updates the bin and writes it back
// a read of a filled bin reads the table, then waits for the bit-serial mean divider;
// an empty or out-of-range bin answers without starting the divider
// after reset a clearing pass writes every bin, with busy high
// each result is shown for one cycle; the receiver cannot stall
`timescale 1ns / 1ps

module binned_min_max_mean_stats
  import bmms_pkg::*;
#(
  parameter int NUM_EVENTS = 256,
  parameter int NUM_SETS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_mode,
  input  logic [7:0]        in_event_id,
  input  logic [3:0]        in_set_index,
  input  logic [EDGE_W-1:0] in_edge_code,
  input  logic [VAL_W-1:0]  in_sample_value,
  output logic              out_valid,
  output logic              out_bin_valid,
  output logic [CNT_W-1:0]  out_sample_count,
  output logic [EDGE_W-1:0] out_bin_edge,
  output logic [VAL_W-1:0]  out_mean_value,
  output logic [VAL_W-1:0]  out_min_value,
  output logic [VAL_W-1:0]  out_max_value,
  output logic              out_edge_mismatch
);

  localparam int DEPTH = NUM_EVENTS * NUM_SETS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $bits(bin_t);

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic              mode_r;
  logic [EDGE_W-1:0] edge_r;
  logic [VAL_W-1:0]  value_r;
  logic [AW-1:0]     addr_r;
  logic              inrange_r;
  bin_t              bin_r, bin_nxt;

  logic              accept;
  logic [31:0]       addr_full;
  logic [AW-1:0]     bin_addr;
  logic              inrange;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BW-1:0]     ram_wdata;
  logic [BW-1:0]     ram_rdata;
  bin_t              rd;
  bin_t              upd;
  logic              mism_now;

  logic              div_start;
  logic              div_done;
  logic [VAL_W-1:0]  div_quotient;

  logic              out_valid_r, out_valid_nxt;
  logic              bin_valid_r, bin_valid_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [EDGE_W-1:0] bedge_r, bedge_nxt;
  logic [VAL_W-1:0]  mean_r, mean_nxt;
  logic [VAL_W-1:0]  min_r, min_nxt;
  logic [VAL_W-1:0]  max_r, max_nxt;
  logic              emis_r, emis_nxt;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // row-major bin address
  assign addr_full = 32'(in_event_id) * 32'(NUM_SETS) + 32'(in_set_index);
  assign bin_addr  = addr_full[AW-1:0];
  assign inrange   = (32'(in_event_id) < 32'(NUM_EVENTS)) &&
                     (32'(in_set_index) < 32'(NUM_SETS));

  bmms_ram #(
    .WIDTH(BW),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(bin_addr),
    .rdata(ram_rdata)
  );

  bmms_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(rd.sum),
    .divisor (rd.cnt),
    .done    (div_done),
    .quotient(div_quotient)
  );

  assign rd = bin_t'(ram_rdata);

  // record update of the bin just read
  always_comb begin
    mism_now = rd.used && (rd.edge_mode != edge_r);
    upd      = rd;
    if (!rd.used) begin
      upd.used      = 1'b1;
      upd.mism      = 1'b0;
      upd.edge_mode = edge_r;
      upd.cnt       = CNT_W'(1);
      upd.sum       = value_r;
      upd.minv      = value_r;
      upd.maxv      = value_r;
    end else begin
      upd.mism = rd.mism | mism_now;
      upd.sum  = rd.sum + value_r;
      if (value_r < rd.minv) begin
        upd.minv = value_r;
      end
      if (value_r > rd.maxv) begin
        upd.maxv = value_r;
      end
      if (rd.cnt != CNT_MAX) begin
        upd.cnt = rd.cnt + 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (inrange_r && mode_r && rd.used) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the control
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = BW'(upd);
    clr_addr_nxt  = clr_addr_r;
    div_start     = 1'b0;
    bin_nxt       = bin_r;
    out_valid_nxt = 1'b0;
    bin_valid_nxt = 1'b0;
    count_nxt     = '0;
    bedge_nxt     = '0;
    mean_nxt      = '0;
    min_nxt       = '0;
    max_nxt       = '0;
    emis_nxt      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      ST_EVAL: begin
        if (!inrange_r) begin
          out_valid_nxt = 1'b1;
        end else if (!mode_r) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          emis_nxt      = mism_now;
        end else if (!rd.used) begin
          out_valid_nxt = 1'b1;
        end else begin
          div_start = 1'b1;
          bin_nxt   = rd;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          bin_valid_nxt = 1'b1;
          count_nxt     = bin_r.cnt;
          bedge_nxt     = bin_r.edge_mode;
          mean_nxt      = div_quotient;
          min_nxt       = bin_r.minv;
          max_nxt       = bin_r.maxv;
          emis_nxt      = bin_r.mism;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_mode;
      edge_r    <= in_edge_code;
      value_r   <= in_sample_value;
      addr_r    <= bin_addr;
      inrange_r <= inrange;
    end
    bin_r       <= bin_nxt;
    bin_valid_r <= bin_valid_nxt;
    count_r     <= count_nxt;
    bedge_r     <= bedge_nxt;
    mean_r      <= mean_nxt;
    min_r       <= min_nxt;
    max_r       <= max_nxt;
    emis_r      <= emis_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_bin_valid     = bin_valid_r;
  assign out_sample_count  = count_r;
  assign out_bin_edge      = bedge_r;
  assign out_mean_value    = mean_r;
  assign out_min_value     = min_r;
  assign out_max_value     = max_r;
  assign out_edge_mismatch = emis_r;

  // a result always follows a cycle of work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request in flight");

  // the table is written back only for an in-range record
  a_write_only_record: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == ST_EVAL) |-> (!mode_r && inrange_r))
    else $error("table write outside an in-range record");

  // the divider finishes only while a readout waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside a readout");

  // a record result carries only the mismatch flag
  a_record_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(state_r == ST_EVAL && !mode_r)) |->
      (!out_bin_valid && out_sample_count == '0 && out_mean_value == '0))
    else $error("record result carries bin statistics");

endmodule

// ----- verif/bmms_tb_pkg.sv -----
// bmms_tb_pkg: request mode codes shared by the statistics table testbench files
// no dependencies
`timescale 1ns / 1ps

package bmms_tb_pkg;

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

endpackage

// ----- verif/bmms_stats_checker.sv -----
// bmms_stats_checker: watches the request and result channels of the statistics table,
// keeps its own copy of every bin and compares each result with the predicted one
// uses bmms_pkg for field widths and bmms_tb_pkg for the mode codes
`timescale 1ns / 1ps

module bmms_stats_checker
  import bmms_pkg::*;
  import bmms_tb_pkg::*;
#(
  parameter int NUM_EVENTS = 256,
  parameter int NUM_SETS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_mode,
  input  logic [7:0]        in_event_id,
  input  logic [3:0]        in_set_index,
  input  logic [EDGE_W-1:0] in_edge_code,
  input  logic [VAL_W-1:0]  in_sample_value,
  input  logic              out_valid,
  input  logic              out_bin_valid,
  input  logic [CNT_W-1:0]  out_sample_count,
  input  logic [EDGE_W-1:0] out_bin_edge,
  input  logic [VAL_W-1:0]  out_mean_value,
  input  logic [VAL_W-1:0]  out_min_value,
  input  logic [VAL_W-1:0]  out_max_value,
  input  logic              out_edge_mismatch,
  output int                errors,
  output int                pending
);

  localparam int BINS = NUM_EVENTS * NUM_SETS;

  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  count;
    logic [EDGE_W-1:0] bin_edge;
    logic [VAL_W-1:0]  mean;
    logic [VAL_W-1:0]  minv;
    logic [VAL_W-1:0]  maxv;
    logic              mism;
  } bin_report_t;

  logic              used_tbl [BINS];
  logic              mism_tbl [BINS];
  logic [VAL_W-1:0]  sum_tbl  [BINS];
  logic [VAL_W-1:0]  min_tbl  [BINS];
  logic [VAL_W-1:0]  max_tbl  [BINS];
  logic [CNT_W-1:0]  cnt_tbl  [BINS];
  logic [EDGE_W-1:0] edge_tbl [BINS];

  bin_report_t report_q [$];
  bin_report_t want, got_pred;
  int          n_predicted = 0;
  int          n_checked   = 0;

  initial errors = 0;
  assign pending = n_predicted - n_checked;

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // applies one request to the bin copy and returns the report it should produce
  task automatic apply_bin_request(input logic mode, input logic [7:0] ev, input logic [3:0] st,
                                   input logic [EDGE_W-1:0] edge_in,
                                   input logic [VAL_W-1:0] v, output bin_report_t rep);
    int b;
    rep = '0;
    if (int'(ev) >= NUM_EVENTS || int'(st) >= NUM_SETS) return;
    b = int'(ev) * NUM_SETS + int'(st);
    if (mode == MODE_RECORD) begin
      if (!used_tbl[b]) begin
        used_tbl[b] = 1'b1;
        mism_tbl[b] = 1'b0;
        edge_tbl[b] = edge_in;
        min_tbl[b]  = v;
        max_tbl[b]  = v;
        sum_tbl[b]  = v;
        cnt_tbl[b]  = 1;
      end else begin
        if (edge_tbl[b] != edge_in) begin
          mism_tbl[b] = 1'b1;
          rep.mism    = 1'b1;
        end
        if (v < min_tbl[b]) min_tbl[b] = v;
        if (v > max_tbl[b]) max_tbl[b] = v;
        sum_tbl[b] = sum_tbl[b] + v;
        if (cnt_tbl[b] != CNT_MAX) cnt_tbl[b] = cnt_tbl[b] + 1'b1;
      end
    end else if (used_tbl[b]) begin
      rep.valid    = 1'b1;
      rep.count    = cnt_tbl[b];
      rep.bin_edge = edge_tbl[b];
      rep.mean     = (cnt_tbl[b] != '0) ? sum_tbl[b] / {{(VAL_W-CNT_W){1'b0}}, cnt_tbl[b]} : '0;
      rep.minv     = min_tbl[b];
      rep.maxv     = max_tbl[b];
      rep.mism     = mism_tbl[b];
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BINS; i++) begin
        used_tbl[i] = 1'b0;
        mism_tbl[i] = 1'b0;
      end
      report_q.delete();
      n_predicted = 0;
      n_checked   = 0;
    end else begin
      // results first: a request taken at this edge cannot answer at the same edge
      if (out_valid) begin
        if (report_q.size() == 0) begin
          flag_error("result strobe with no request outstanding");
        end else begin
          want = report_q.pop_front();
          n_checked++;
          if (out_bin_valid !== want.valid)
            flag_error($sformatf("bin_valid: expected %0d, got %0d", want.valid, out_bin_valid));
          if (out_sample_count !== want.count)
            flag_error($sformatf("sample_count: expected %0d, got %0d",
                                 want.count, out_sample_count));
          if (out_bin_edge !== want.bin_edge)
            flag_error($sformatf("bin_edge: expected %h, got %h", want.bin_edge, out_bin_edge));
          if (out_mean_value !== want.mean)
            flag_error($sformatf("mean_value: expected %h, got %h", want.mean, out_mean_value));
          if (out_min_value !== want.minv)
            flag_error($sformatf("min_value: expected %h, got %h", want.minv, out_min_value));
          if (out_max_value !== want.maxv)
            flag_error($sformatf("max_value: expected %h, got %h", want.maxv, out_max_value));
          if (out_edge_mismatch !== want.mism)
            flag_error($sformatf("edge_mismatch: expected %0d, got %0d",
                                 want.mism, out_edge_mismatch));
        end
      end
      if (start && !busy) begin
        apply_bin_request(in_mode, in_event_id, in_set_index, in_edge_code, in_sample_value,
                          got_pred);
        report_q.push_back(got_pred);
        n_predicted++;
      end
    end
  end

endmodule

// ----- verif/tb.sv -----
// tb: stimulus and verdict for binned_min_max_mean_stats
// depends on bmms_pkg, bmms_tb_pkg, bmms_stats_checker and the block itself
`timescale 1ns / 1ps

module tb;
  import bmms_pkg::*;
  import bmms_tb_pkg::*;

  localparam int NUM_EVENTS   = 256;
  localparam int NUM_SETS     = 16;
  localparam int HOT_BINS     = 12;
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_EVERY  = 200;
  localparam int TAIL_CYCLES  = 100;
  // covers the clearing pass after reset with a wide margin
  localparam int STALL_LIMIT  = 20000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_mode;
  logic [7:0]        in_event_id;
  logic [3:0]        in_set_index;
  logic [EDGE_W-1:0] in_edge_code;
  logic [VAL_W-1:0]  in_sample_value;
  logic              out_valid;
  logic              out_bin_valid;
  logic [CNT_W-1:0]  out_sample_count;
  logic [EDGE_W-1:0] out_bin_edge;
  logic [VAL_W-1:0]  out_mean_value;
  logic [VAL_W-1:0]  out_min_value;
  logic [VAL_W-1:0]  out_max_value;
  logic              out_edge_mismatch;

  int errors;
  int pending;
  int idle_cycles = 0;

  logic [7:0]        hot_ev   [HOT_BINS];
  logic [3:0]        hot_st   [HOT_BINS];
  logic [EDGE_W-1:0] hot_edge [HOT_BINS];
  logic [VAL_W-1:0]  hot_base [HOT_BINS];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  binned_min_max_mean_stats #(
    .NUM_EVENTS(NUM_EVENTS),
    .NUM_SETS  (NUM_SETS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_event_id      (in_event_id),
    .in_set_index     (in_set_index),
    .in_edge_code     (in_edge_code),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_bin_valid    (out_bin_valid),
    .out_sample_count (out_sample_count),
    .out_bin_edge     (out_bin_edge),
    .out_mean_value   (out_mean_value),
    .out_min_value    (out_min_value),
    .out_max_value    (out_max_value),
    .out_edge_mismatch(out_edge_mismatch)
  );

  bmms_stats_checker #(
    .NUM_EVENTS(NUM_EVENTS),
    .NUM_SETS  (NUM_SETS)
  ) stats_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_event_id      (in_event_id),
    .in_set_index     (in_set_index),
    .in_edge_code     (in_edge_code),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_bin_valid    (out_bin_valid),
    .out_sample_count (out_sample_count),
    .out_bin_edge     (out_bin_edge),
    .out_mean_value   (out_mean_value),
    .out_min_value    (out_min_value),
    .out_max_value    (out_max_value),
    .out_edge_mismatch(out_edge_mismatch),
    .errors           (errors),
    .pending          (pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // called at a rising edge; returns at the edge that takes the request
  task automatic issue_request(input logic mode, input logic [7:0] ev, input logic [3:0] st,
                               input logic [EDGE_W-1:0] edge_code, input logic [VAL_W-1:0] v);
    start           <= 1'b1;
    in_mode         <= mode;
    in_event_id     <= ev;
    in_set_index    <= st;
    in_edge_code    <= edge_code;
    in_sample_value <= v;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic go_quiet(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(input logic [VAL_W-1:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2: return {$urandom, $urandom};
      3, 4:    return 64'($urandom_range(0, 1000));
      5, 6:    return base + 64'($urandom_range(0, 4096));
      7:       return '0;
      8:       return '1;
      default: return '1 - 64'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int                sent;
    int                last_drain;
    int                burst;
    int                h;
    logic              mode;
    logic [7:0]        ev;
    logic [3:0]        st;
    logic [EDGE_W-1:0] edge_code;
    logic [VAL_W-1:0]  base;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_mode         <= MODE_RECORD;
    in_event_id     <= '0;
    in_set_index    <= '0;
    in_edge_code    <= '0;
    in_sample_value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first bin: first sample, extreme values, edge mismatch, sum wraps to 4
    issue_request(MODE_RECORD, 8'd0, 4'd0, 16'h0000, 64'd5);
    issue_request(MODE_RECORD, 8'd0, 4'd0, 16'h0000, '1);
    issue_request(MODE_RECORD, 8'd0, 4'd0, 16'hffff, '0);
    issue_request(MODE_READ, 8'd0, 4'd0, 16'h0000, '0);
    // last row and column, all-ones values twice
    issue_request(MODE_READ, 8'd255, 4'd15, 16'hffff, '1);
    issue_request(MODE_RECORD, 8'd255, 4'd15, 16'hffff, '1);
    issue_request(MODE_RECORD, 8'd255, 4'd15, 16'hffff, '1);
    issue_request(MODE_READ, 8'd255, 4'd15, 16'hffff, '1);
    // empty bin, then a single sample with only the top bit set
    issue_request(MODE_READ, 8'd128, 4'd7, 16'h5a5a, 64'h8000_0000_0000_0000);
    issue_request(MODE_RECORD, 8'd128, 4'd7, 16'h5a5a, 64'h8000_0000_0000_0000);
    issue_request(MODE_READ, 8'd128, 4'd7, 16'h0000, '0);
    // new min and max after the first sample, one late edge change
    issue_request(MODE_RECORD, 8'd1, 4'd8, 16'h0003, 64'd100);
    issue_request(MODE_RECORD, 8'd1, 4'd8, 16'h0003, 64'd50);
    issue_request(MODE_RECORD, 8'd1, 4'd8, 16'h0004, 64'd200);
    issue_request(MODE_RECORD, 8'd1, 4'd8, 16'h0003, 64'd150);
    issue_request(MODE_READ, 8'd1, 4'd8, 16'h0000, '0);
    // neighbors of used bins stay empty, then the first bin is read again
    issue_request(MODE_READ, 8'd1, 4'd9, 16'h0000, '0);
    issue_request(MODE_READ, 8'd254, 4'd15, 16'h0000, '0);
    issue_request(MODE_READ, 8'd0, 4'd0, 16'h0000, '0);
    drain_results();

    for (int i = 0; i < HOT_BINS; i++) begin
      hot_ev[i]   = 8'($urandom);
      hot_st[i]   = 4'($urandom);
      hot_edge[i] = 16'($urandom);
      hot_base[i] = (i % 3 == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 100000));
    end

    sent       = 0;
    last_drain = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 80))
                                          : int'($urandom_range(1, 16));
      repeat (burst) begin
        // most requests land on a few bins so statistics build up
        if ($urandom_range(0, 99) < 75) begin
          h         = int'($urandom_range(0, HOT_BINS - 1));
          ev        = hot_ev[h];
          st        = hot_st[h];
          edge_code = ($urandom_range(0, 9) == 0) ? 16'($urandom) : hot_edge[h];
          base      = hot_base[h];
        end else begin
          ev        = 8'($urandom);
          st        = 4'($urandom);
          edge_code = 16'($urandom);
          base      = {$urandom, $urandom};
        end
        mode = ($urandom_range(0, 4) == 0) ? MODE_READ : MODE_RECORD;
        issue_request(mode, ev, st, edge_code, pick_value(base));
        sent++;
      end
      if (sent - last_drain >= DRAIN_EVERY) begin
        drain_results();
        last_drain = sent;
      end else begin
        go_quiet(int'($urandom_range(1, 10)));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/bmms_pkg.sv
design/bmms_ram.sv
design/bmms_div.sv
design/binned_min_max_mean_stats.sv
verif/bmms_tb_pkg.sv
verif/bmms_stats_checker.sv
verif/tb.sv
